FILE: rtl/tssa_pkg.sv
package tssa_pkg;

    // Width of the capacity register and of both stack counters.
    localparam int CAP_W = 7;

    // Width of the streamed element fields.
    localparam int ITEM_W = 32;

    typedef enum logic [2:0] {
        CMD_PUSH_ONE = 3'd0,
        CMD_PUSH_TWO = 3'd1,
        CMD_POP_ONE  = 3'd2,
        CMD_POP_TWO  = 3'd3,
        CMD_DUMP_ONE = 3'd4,
        CMD_DUMP_TWO = 3'd5
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_WALK = 2'b10
    } state_t;

    // Write and read requests from the control logic to the store.
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } mem_req_t;

endpackage

FILE: rtl/tssa_store.sv
module tssa_store
    import tssa_pkg::*;
#(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic                         aclk,
    input  mem_req_t                     req,
    input  logic [$clog2(DEPTH)-1:0]     wr_addr,
    input  logic [DATA_WIDTH-1:0]        wr_data,
    input  logic [$clog2(DEPTH)-1:0]     rd_addr,
    output logic [DATA_WIDTH-1:0]        rd_data
);

    logic [DATA_WIDTH-1:0] mem [DEPTH];
    logic [DATA_WIDTH-1:0] rd_data_reg;

    // Simple dual-port store; the read data holds while no read is issued.
    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (req.rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/two_stack_shared_array_top.sv
// Channel  | Direction | Signals                          | Contents
// s_       | in        | s_tvalid s_tready s_tdata s_tuser | value, command
// m_       | out       | m_tvalid m_tready m_tdata m_tuser | data, status; m_tlast = last
// cfg_     | in        | cfg_valid cfg_ready cfg_data      | capacity
//
// A push, a refused push and any empty pop or dump are answered from the idle
// state. A pop or a dump reads the store through its single registered read
// port and then walks, moving each element to the output register and issuing
// any further read. Reset is synchronous and active low; it empties both stacks
// and sets the capacity to DEPTH, while the store contents stay undefined. A
// stall on the result side holds the walk; an input item is taken only while
// the output register is empty or its result leaves in that same cycle.
module two_stack_shared_array_top
    import tssa_pkg::*;
#(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic              aclk,
    input  logic              aresetn,

    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [31:0]       s_tdata,   // [31:0] value
    input  logic [2:0]        s_tuser,   // [2:0] command

    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [31:0]       m_tdata,   // [31:0] data
    output logic [1:0]        m_tuser,   // [1:0] status
    output logic              m_tlast,

    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CAP_W-1:0]  cfg_data
);

    localparam int AW    = $clog2(DEPTH);
    // Common width for moving elements between the 32-bit ports and the store.
    localparam int EXT_W = (DATA_WIDTH > ITEM_W) ? DATA_WIDTH : ITEM_W;

    state_t              state_reg, state_next;
    logic [CAP_W-1:0]    capacity_reg, capacity_next;
    logic [CAP_W-1:0]    count_one_reg, count_one_next;
    logic [CAP_W-1:0]    count_two_reg, count_two_next;
    // Walk state: next address to read, reads still to issue, and whether
    // the read in flight is the last element of the pop or dump.
    logic [AW-1:0]       addr_reg, addr_next;
    logic [CAP_W-1:0]    left_reg, left_next;
    logic                rd_last_reg, rd_last_next;
    logic                step_up_reg, step_up_next;

    logic                m_valid_reg, m_valid_next;
    logic [31:0]         m_data_reg, m_data_next;
    status_t             m_status_reg, m_status_next;
    logic                m_last_reg, m_last_next;

    mem_req_t            req;
    logic [AW-1:0]       wr_addr;
    logic [AW-1:0]       rd_addr;
    logic [DATA_WIDTH-1:0] rd_data;
    logic [DATA_WIDTH-1:0] wr_data;
    logic [EXT_W-1:0]    in_ext;
    logic [EXT_W-1:0]    rd_ext;

    logic                out_free;
    logic                in_acc;
    logic                cfg_acc;
    logic [CAP_W:0]      total;
    cmd_t                cmd;
    logic [CAP_W-1:0]    cap_clamped;
    logic [CAP_W-1:0]    top_one;
    logic [CAP_W-1:0]    top_two;

    tssa_store #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_store (
        .aclk    (aclk),
        .req     (req),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Elements are zero-extended or cut to the store width and back.
    assign in_ext  = EXT_W'(s_tdata);
    assign wr_data = in_ext[DATA_WIDTH-1:0];
    assign rd_ext  = EXT_W'(rd_data);

    // The output register can take a new result when empty or being drained.
    assign out_free  = !m_valid_reg || m_tready;
    assign s_tready  = (state_reg == S_IDLE) && out_free;
    assign cfg_ready = (state_reg == S_IDLE);
    assign in_acc    = s_tvalid && s_tready;
    assign cfg_acc   = cfg_valid && cfg_ready;
    assign cmd       = cmd_t'(s_tuser);
    assign total     = {1'b0, count_one_reg} + {1'b0, count_two_reg};

    // Top elements: stack one at count_one - 1, stack two at capacity - count_two.
    assign top_one = count_one_reg - CAP_W'(1);
    assign top_two = capacity_reg - count_two_reg;

    always_comb begin
        if (cfg_data == '0) begin
            cap_clamped = CAP_W'(1);
        end else if (cfg_data > CAP_W'(DEPTH)) begin
            cap_clamped = CAP_W'(DEPTH);
        end else begin
            cap_clamped = cfg_data;
        end
    end

    always_comb begin
        state_next     = state_reg;
        capacity_next  = capacity_reg;
        count_one_next = count_one_reg;
        count_two_next = count_two_reg;
        addr_next      = addr_reg;
        left_next      = left_reg;
        rd_last_next   = rd_last_reg;
        step_up_next   = step_up_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        m_data_next    = m_data_reg;
        m_status_next  = m_status_reg;
        m_last_next    = m_last_reg;
        req            = '0;
        wr_addr        = AW'(count_one_reg);
        rd_addr        = addr_reg;

        case (state_reg)
            S_IDLE: begin
                if (in_acc) begin
                    case (cmd)
                        CMD_PUSH_ONE, CMD_PUSH_TWO: begin
                            m_valid_next = 1'b1;
                            m_data_next  = '0;
                            m_last_next  = 1'b1;
                            if (total >= {1'b0, capacity_reg}) begin
                                m_status_next = ST_FULL;
                            end else begin
                                m_status_next = ST_OK;
                                req.wr_en     = 1'b1;
                                if (cmd == CMD_PUSH_ONE) begin
                                    wr_addr        = AW'(count_one_reg);
                                    count_one_next = count_one_reg + CAP_W'(1);
                                end else begin
                                    wr_addr        = AW'(top_two - CAP_W'(1));
                                    count_two_next = count_two_reg + CAP_W'(1);
                                end
                            end
                        end
                        CMD_POP_ONE, CMD_DUMP_ONE: begin
                            if (count_one_reg == '0) begin
                                m_valid_next  = 1'b1;
                                m_data_next   = '0;
                                m_status_next = ST_EMPTY;
                                m_last_next   = 1'b1;
                            end else begin
                                req.rd_en    = 1'b1;
                                rd_addr      = AW'(top_one);
                                addr_next    = AW'(top_one) - AW'(1);
                                step_up_next = 1'b0;
                                state_next   = S_WALK;
                                if (cmd == CMD_POP_ONE) begin
                                    count_one_next = top_one;
                                    left_next      = '0;
                                    rd_last_next   = 1'b1;
                                end else begin
                                    left_next    = top_one;
                                    rd_last_next = (count_one_reg == CAP_W'(1));
                                end
                            end
                        end
                        CMD_POP_TWO, CMD_DUMP_TWO: begin
                            if (count_two_reg == '0) begin
                                m_valid_next  = 1'b1;
                                m_data_next   = '0;
                                m_status_next = ST_EMPTY;
                                m_last_next   = 1'b1;
                            end else begin
                                req.rd_en    = 1'b1;
                                rd_addr      = AW'(top_two);
                                addr_next    = AW'(top_two) + AW'(1);
                                step_up_next = 1'b1;
                                state_next   = S_WALK;
                                if (cmd == CMD_POP_TWO) begin
                                    count_two_next = count_two_reg - CAP_W'(1);
                                    left_next      = '0;
                                    rd_last_next   = 1'b1;
                                end else begin
                                    left_next    = count_two_reg - CAP_W'(1);
                                    rd_last_next = (count_two_reg == CAP_W'(1));
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                if (cfg_acc) begin
                    capacity_next  = cap_clamped;
                    count_one_next = '0;
                    count_two_next = '0;
                end
            end
            S_WALK: begin
                // When the output register is free, the read data in the store register moves
                // to the output, and any further read is issued in the same cycle.
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_data_next   = rd_ext[31:0];
                    m_status_next = ST_OK;
                    m_last_next   = rd_last_reg;
                    if (left_reg != '0) begin
                        req.rd_en    = 1'b1;
                        rd_addr      = addr_reg;
                        addr_next    = step_up_reg ? addr_reg + AW'(1) : addr_reg - AW'(1);
                        left_next    = left_reg - CAP_W'(1);
                        rd_last_next = (left_reg == CAP_W'(1));
                    end else begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            capacity_reg  <= CAP_W'(DEPTH);
            count_one_reg <= '0;
            count_two_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            capacity_reg  <= capacity_next;
            count_one_reg <= count_one_next;
            count_two_reg <= count_two_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        addr_reg     <= addr_next;
        left_reg     <= left_next;
        rd_last_reg  <= rd_last_next;
        step_up_reg  <= step_up_next;
        m_data_reg   <= m_data_next;
        m_status_reg <= m_status_next;
        m_last_reg   <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_status_reg;
    assign m_tlast  = m_last_reg;

endmodule
